[design/imucaf_pkg.sv]
// Shared types, constants and helper functions for the IMU attitude filter.
// No dependencies.
package imucaf_pkg;

	localparam int AXES            = 3;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STEPS    = 16;
	localparam int INC_SHIFT       = 24 - ANGLE_FRAC_BITS;
	localparam int CNT_W           = $clog2(CORDIC_STEPS + 1);
	localparam int CORD_W          = 34;

	localparam logic [16:0] ONE_Q15  = 17'd32768;
	localparam logic [24:0] STEP_MAX = 25'd16777216;

	typedef enum logic [2:0] {
		REG_BIAS_X    = 3'd0,
		REG_BIAS_Y    = 3'd1,
		REG_BIAS_Z    = 3'd2,
		REG_ACC_SMOOTH = 3'd3,
		REG_GYR_SMOOTH = 3'd4,
		REG_RATE_STEP = 3'd5,
		REG_TRUST     = 3'd6,
		REG_FILT_EN   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] smooth_accel_x;
		logic signed [15:0] smooth_accel_y;
		logic signed [15:0] smooth_accel_z;
		logic signed [15:0] smooth_rate_x;
		logic signed [15:0] smooth_rate_y;
		logic signed [15:0] smooth_rate_z;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] roll_angle;
		logic signed [31:0] yaw_angle;
	} out_item_t;

	typedef struct packed {
		logic cap_in;
		logic cap_prod;
		logic cap_y;
		logic cap_inc;
		logic cap_g;
		logic filt_en;
	} lane_ctrl_t;

	function automatic logic [16:0] sat_coef(input logic [15:0] c);
		sat_coef = ({1'b0, c} > ONE_Q15) ? ONE_Q15 : {1'b0, c};
	endfunction

	// atan(2^-i) in degrees, Q24
	function automatic logic [30:0] atan_q24(input logic [4:0] i);
		unique case (i)
			5'd0:  atan_q24 = 31'd754974720;
			5'd1:  atan_q24 = 31'd445687602;
			5'd2:  atan_q24 = 31'd235489088;
			5'd3:  atan_q24 = 31'd119537938;
			5'd4:  atan_q24 = 31'd60000934;
			5'd5:  atan_q24 = 31'd30029717;
			5'd6:  atan_q24 = 31'd15018523;
			5'd7:  atan_q24 = 31'd7509720;
			5'd8:  atan_q24 = 31'd3754917;
			5'd9:  atan_q24 = 31'd1877466;
			5'd10: atan_q24 = 31'd938734;
			5'd11: atan_q24 = 31'd469367;
			5'd12: atan_q24 = 31'd234684;
			5'd13: atan_q24 = 31'd117342;
			5'd14: atan_q24 = 31'd58671;
			5'd15: atan_q24 = 31'd29335;
			5'd16: atan_q24 = 31'd14668;
			5'd17: atan_q24 = 31'd7334;
			5'd18: atan_q24 = 31'd3667;
			5'd19: atan_q24 = 31'd1833;
			5'd20: atan_q24 = 31'd917;
			5'd21: atan_q24 = 31'd458;
			5'd22: atan_q24 = 31'd229;
			5'd23: atan_q24 = 31'd115;
			default: atan_q24 = 31'd0;
		endcase
	endfunction

endpackage

[design/imucaf_lane.sv]
// One axis lane: bias removal, first-order low-pass of accel and gyro, rate integration.
// Depends on imucaf_pkg.
module imucaf_lane
	import imucaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic signed [15:0] accel,
	input  logic signed [15:0] rate,
	input  logic signed [15:0] bias,
	input  logic        [16:0] acc_coef,
	input  logic        [16:0] gyr_coef,
	input  logic        [24:0] step,
	input  logic signed [31:0] ang_state,
	output logic signed [15:0] acc_y,
	output logic signed [15:0] rate_y,
	output logic signed [31:0] gyro_ang
);

	logic signed [15:0] acc_raw_q, rate_raw_q;
	logic signed [33:0] pa_new_q, pa_old_q, pr_new_q, pr_old_q;
	logic signed [15:0] acc_y_q, rate_y_q;
	logic signed [31:0] inc_q, g_q;
	logic signed [17:0] aa_s, aa_inv, ga_s, ga_inv;
	logic signed [34:0] acc_sum, rate_sum, acc_adj, rate_adj;
	logic signed [34:0] acc_shr, rate_shr;
	logic signed [41:0] inc_prod, inc_shr;

	assign aa_s   = $signed({1'b0, acc_coef});
	assign ga_s   = $signed({1'b0, gyr_coef});
	assign aa_inv = $signed({1'b0, ONE_Q15}) - aa_s;
	assign ga_inv = $signed({1'b0, ONE_Q15}) - ga_s;

	// truncate toward zero: bias negative sums before the shift
	assign acc_sum  = 35'(pa_new_q) + 35'(pa_old_q);
	assign rate_sum = 35'(pr_new_q) + 35'(pr_old_q);
	assign acc_adj  = acc_sum + (acc_sum[34] ? 35'sd32767 : 35'sd0);
	assign rate_adj = rate_sum + (rate_sum[34] ? 35'sd32767 : 35'sd0);
	assign acc_shr  = acc_adj >>> 15;
	assign rate_shr = rate_adj >>> 15;

	assign inc_prod = 42'(rate_y_q) * $signed({17'd0, step});
	assign inc_shr  = inc_prod >>> INC_SHIFT;

	always_ff @(posedge clk) begin
		if (ctrl.cap_in) begin
			acc_raw_q  <= accel;
			rate_raw_q <= rate - bias;
		end
		if (ctrl.cap_prod) begin
			pa_new_q <= 34'(aa_s) * 34'(acc_raw_q);
			pa_old_q <= 34'(aa_inv) * 34'(acc_y_q);
			pr_new_q <= 34'(ga_s) * 34'(rate_raw_q);
			pr_old_q <= 34'(ga_inv) * 34'(rate_y_q);
		end
		if (ctrl.cap_inc) begin
			inc_q <= inc_shr[31:0];
		end
		if (ctrl.cap_g) begin
			g_q <= ang_state + inc_q;
		end
	end

	// filtered values double as the low-pass history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_y_q  <= '0;
			rate_y_q <= '0;
		end else if (ctrl.cap_y) begin
			acc_y_q  <= ctrl.filt_en ? acc_shr[15:0] : acc_raw_q;
			rate_y_q <= ctrl.filt_en ? rate_shr[15:0] : rate_raw_q;
		end
	end

	assign acc_y    = acc_y_q;
	assign rate_y   = rate_y_q;
	assign gyro_ang = g_q;

endmodule

[design/imucaf_cordic.sv]
// Iterative vectoring CORDIC atan2(y, x) in degrees, one rotation per cycle.
// Depends on imucaf_pkg.
module imucaf_cordic
	import imucaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] y_in,
	input  logic signed [15:0] x_in,
	output logic               done,
	output logic signed [31:0] angle
);

	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q, fin_q, done_q, zero_q;
	logic signed [31:0]       angle_q;
	logic signed [CORD_W-1:0] xs, ys, dx, dy, z_rnd;
	logic signed [CORD_W-1:0] ang_step;

	assign xs = CORD_W'(x_in) <<< 14;
	assign ys = CORD_W'(y_in) <<< 14;
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign ang_step = $signed({{(CORD_W-31){1'b0}}, atan_q24(5'(cnt_q))});
	assign z_rnd = (z_q + (CORD_W'(1) <<< (INC_SHIFT - 1))) >>> INC_SHIFT;

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (xs[CORD_W-1]) begin
				if (!ys[CORD_W-1]) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= CORD_W'(90 * 16777216);
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -CORD_W'(90 * 16777216);
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CORD_W-1] && (y_q != '0)) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang_step;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang_step;
			end
		end
		if (fin_q) begin
			angle_q <= zero_q ? 32'sd0 : z_rnd[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

[design/imu_complementary_attitude_filter_core.sv]
// Top level: register file, sequencer, three axis lanes, two CORDIC lanes, blend and output.
// Depends on imucaf_pkg, imucaf_lane, imucaf_cordic.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (in_item_t)
//  out     | output    | out_valid/out_stall| out_data (out_item_t)
//  config  | input     | psel/penable/pready| paddr, pwdata, prdata
//
// An item passes ST_MUL, ST_SUM, ST_INT, ST_ADD, ST_CORD (iterative CORDIC atan2), ST_BMUL
// and ST_BADD from acceptance to result; one item is in work at a time, so a new item is
// taken only once the previous one has committed.
// arst_n clears filter history, angle states, registers to their defaults and control.
// A held result waits in the output register while the next item is accepted; the
// final commit waits while that register is still full and out_stall is high.
module imu_complementary_attitude_filter_core
	import imucaf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_SUM  = 8'b0000_0100,
		ST_INT  = 8'b0000_1000,
		ST_ADD  = 8'b0001_0000,
		ST_CORD = 8'b0010_0000,
		ST_BMUL = 8'b0100_0000,
		ST_BADD = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [15:0] bias_x_q, bias_y_q, bias_z_q;
	logic        [15:0] acc_smooth_q, gyr_smooth_q, trust_q;
	logic        [24:0] step_q;
	logic               filt_en_q;
	logic signed [31:0] pitch_q, roll_q, yaw_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               wr_en, accept, commit;
	reg_idx_t           wr_idx;
	lane_ctrl_t         ctrl;
	logic        [16:0] aa, ga, tt;
	logic        [24:0] step_sat;
	logic signed [15:0] acc_y [AXES];
	logic signed [15:0] rate_y [AXES];
	logic signed [31:0] gang [AXES];
	logic signed [31:0] pitch_acc, roll_acc;
	logic               pitch_done, roll_done;
	logic signed [49:0] bp_g_s1, bp_a_s1, br_g_s1, br_a_s1;
	logic signed [17:0] t_s, t_inv;
	logic signed [50:0] pitch_sum, roll_sum;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = reg_idx_t'(paddr[4:2]);
	assign accept = in_valid && !in_stall;
	assign commit = (state_q == ST_BADD) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);

	assign aa = sat_coef(acc_smooth_q);
	assign ga = sat_coef(gyr_smooth_q);
	assign tt = sat_coef(trust_q);
	assign step_sat = (step_q > STEP_MAX) ? STEP_MAX : step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_x_q     <= '0;
			bias_y_q     <= '0;
			bias_z_q     <= '0;
			acc_smooth_q <= 16'd32768;
			gyr_smooth_q <= 16'd32768;
			step_q       <= 25'd16777;
			trust_q      <= 16'd32113;
			filt_en_q    <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_BIAS_X:     bias_x_q     <= pwdata[15:0];
				REG_BIAS_Y:     bias_y_q     <= pwdata[15:0];
				REG_BIAS_Z:     bias_z_q     <= pwdata[15:0];
				REG_ACC_SMOOTH: acc_smooth_q <= pwdata[15:0];
				REG_GYR_SMOOTH: gyr_smooth_q <= pwdata[15:0];
				REG_RATE_STEP:  step_q       <= pwdata[24:0];
				REG_TRUST:      trust_q      <= pwdata[15:0];
				REG_FILT_EN:    filt_en_q    <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_BIAS_X:     prdata = 32'($unsigned(bias_x_q));
			REG_BIAS_Y:     prdata = 32'($unsigned(bias_y_q));
			REG_BIAS_Z:     prdata = 32'($unsigned(bias_z_q));
			REG_ACC_SMOOTH: prdata = 32'(acc_smooth_q);
			REG_GYR_SMOOTH: prdata = 32'(gyr_smooth_q);
			REG_RATE_STEP:  prdata = 32'(step_q);
			REG_TRUST:      prdata = 32'(trust_q);
			REG_FILT_EN:    prdata = 32'(filt_en_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_INT;
				ST_INT:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_CORD;
				ST_CORD: if (pitch_done) state_q <= ST_BMUL;
				ST_BMUL: state_q <= ST_BADD;
				ST_BADD: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl.cap_in   = accept;
		ctrl.cap_prod = (state_q == ST_MUL);
		ctrl.cap_y    = (state_q == ST_SUM);
		ctrl.cap_inc  = (state_q == ST_INT);
		ctrl.cap_g    = (state_q == ST_ADD);
		ctrl.filt_en  = filt_en_q;
	end

	imucaf_lane u_lane_x (
		.clk, .arst_n, .ctrl,
		.accel(in_data.accel_x), .rate(in_data.rate_x), .bias(bias_x_q),
		.acc_coef(aa), .gyr_coef(ga), .step(step_sat), .ang_state(pitch_q),
		.acc_y(acc_y[0]), .rate_y(rate_y[0]), .gyro_ang(gang[0])
	);
	imucaf_lane u_lane_y (
		.clk, .arst_n, .ctrl,
		.accel(in_data.accel_y), .rate(in_data.rate_y), .bias(bias_y_q),
		.acc_coef(aa), .gyr_coef(ga), .step(step_sat), .ang_state(roll_q),
		.acc_y(acc_y[1]), .rate_y(rate_y[1]), .gyro_ang(gang[1])
	);
	imucaf_lane u_lane_z (
		.clk, .arst_n, .ctrl,
		.accel(in_data.accel_z), .rate(in_data.rate_z), .bias(bias_z_q),
		.acc_coef(aa), .gyr_coef(ga), .step(step_sat), .ang_state(yaw_q),
		.acc_y(acc_y[2]), .rate_y(rate_y[2]), .gyro_ang(gang[2])
	);

	imucaf_cordic u_cordic_pitch (
		.clk, .arst_n, .start(state_q == ST_INT),
		.y_in(acc_y[1]), .x_in(acc_y[2]), .done(pitch_done), .angle(pitch_acc)
	);
	imucaf_cordic u_cordic_roll (
		.clk, .arst_n, .start(state_q == ST_INT),
		.y_in(acc_y[0]), .x_in(acc_y[2]), .done(roll_done), .angle(roll_acc)
	);

	assign t_s   = $signed({1'b0, tt});
	assign t_inv = $signed({1'b0, ONE_Q15}) - t_s;

	// blend products; roll takes the negated tilt
	always_ff @(posedge clk) begin
		if (state_q == ST_BMUL) begin
			bp_g_s1 <= 50'(t_s) * 50'(gang[0]);
			bp_a_s1 <= 50'(t_inv) * 50'(pitch_acc);
			br_g_s1 <= 50'(t_s) * 50'(gang[1]);
			br_a_s1 <= 50'(t_inv) * (-50'(roll_acc));
		end
	end

	assign pitch_sum = (51'(bp_g_s1) + 51'(bp_a_s1) + 51'sd16384) >>> 15;
	assign roll_sum  = (51'(br_g_s1) + 51'(br_a_s1) + 51'sd16384) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q     <= '0;
			roll_q      <= '0;
			yaw_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (commit) begin
				pitch_q     <= pitch_sum[31:0];
				roll_q      <= roll_sum[31:0];
				yaw_q       <= gang[2];
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.smooth_accel_x <= acc_y[0];
			out_q.smooth_accel_y <= acc_y[1];
			out_q.smooth_accel_z <= acc_y[2];
			out_q.smooth_rate_x  <= rate_y[0];
			out_q.smooth_rate_y  <= rate_y[1];
			out_q.smooth_rate_z  <= rate_y[2];
			out_q.pitch_angle    <= pitch_sum[31:0];
			out_q.roll_angle     <= roll_sum[31:0];
			out_q.yaw_angle      <= gang[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second transaction taken while one is in work");
	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_done == roll_done)
		else $error("tilt lanes out of step");
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid || !out_stall))
		else $error("result overwrote a pending transaction");
`endif

endmodule
